/* rtl/core/svm_pkg.sv */
// shared types, constants and gain table for the stereo voice mixer
`timescale 1ns / 1ps
package svm_pkg;

  localparam int unsigned SampleBits   = 16;
  localparam int unsigned PositionBits = 24;
  localparam int unsigned BufferBits   = 12;
  localparam int unsigned TableBits    = 8;
  localparam int unsigned TableSize    = 1 << TableBits;
  localparam int unsigned VolBits      = 17;
  localparam int unsigned PanBits      = 16;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 24;
  localparam int unsigned DivNumBits   = VolBits + BufferBits;
  localparam int unsigned DivDenBits   = BufferBits + 1;
  localparam int unsigned MulABits     = 34;
  localparam int unsigned MulBBits     = 18;
  localparam int unsigned MulPBits     = MulABits + MulBBits;

  localparam logic [CfgIdxBits-1:0] CFG_SOUND_LENGTH  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_LOOP_ENABLE   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_TARGET_VOLUME = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_TARGET_PAN    = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_BUFFER_FRAMES = 3'd4;

  localparam logic [VolBits-1:0]    UNITY_VOLUME = 17'h10000;
  localparam logic [VolBits-1:0]    UNITY_GAIN   = 17'h08000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_VMUL, ST_VDIV, ST_VWAIT, ST_PMUL, ST_PDIV, ST_PWAIT,
    ST_GAIN, ST_LMUL1, ST_LMUL2, ST_RMUL1, ST_RMUL2, ST_RRND, ST_DONE
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [DivNumBits-1:0] dividend;
    logic [DivDenBits-1:0] divisor;
  } div_req_t;

  typedef logic [TableSize-1:0][15:0] gain_tab_t;

  // shift and subtract long division, only used to build the table
  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [15:0] sine_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned sd [6];
    logic [63:0] r;
    sd = '{156, 110, 72, 42, 20, 6};
    x  = (longint'(k) * 64'd1686629713) >> TableBits;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int j = 0; j < 6; j++) begin
      t = (64'd1 << 30) - long_div((x2 * t) >> 30, sd[j]);
    end
    r = (((x * t) >> 30) + 64'd16384) >> 15;
    return r[15:0];
  endfunction

  function automatic gain_tab_t build_gain_tab();
    gain_tab_t tab;
    for (int unsigned k = 0; k < TableSize; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam gain_tab_t GAIN_TAB = build_gain_tab();

endpackage

/* rtl/core/svm_div.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module svm_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  svm_pkg::div_req_t                req_i,
  output logic                             done_o,
  output logic [svm_pkg::DivNumBits-1:0]   quotient_o
);
  import svm_pkg::*;

  localparam int unsigned CntBits = $clog2(DivNumBits + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [DivDenBits-1:0] rem_q, rem_d;
  logic [DivDenBits-1:0] dvs_q, dvs_d;
  logic [DivNumBits-1:0] quo_q, quo_d;
  logic [DivDenBits:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[DivNumBits-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DivNumBits);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DivDenBits'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DivNumBits-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDenBits-1:0];
        quo_d = {quo_q[DivNumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/svm_mul.sv */
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module svm_mul (
  input  logic                                  clk_i,
  input  logic signed [svm_pkg::MulABits-1:0]   a_i,
  input  logic signed [svm_pkg::MulBBits-1:0]   b_i,
  output logic signed [svm_pkg::MulPBits-1:0]   p_o
);
  import svm_pkg::*;

  logic signed [MulPBits-1:0] p_q, p_d;

  always_comb begin
    p_d = MulPBits'(a_i) * MulPBits'(b_i);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* rtl/core/stereo_voice_mixer_ramped_pan.sv */
// top level: equal-power pan mixer with linear volume and pan ramps
// One stereo frame is taken per transaction and at most one scaled frame is returned. The
// frame count of a buffer is fixed on its first frame; volume and pan ramp linearly from the
// previous buffer's targets. Each item runs, from one accepted transaction to the next, through
// the accept, a start step on the first frame of a buffer, two passes of the shared bit-serial
// divider (a start, 29 quotient bits and a done strobe) for the volume and pan ramp fractions,
// one multiplier pass ahead of each, then the gain lookup, four more multiplier passes,
// rounding and the output load; a stalled output register adds its wait to the last of these.
// A finished frame waits in the output register, so the next frame can be taken while it is
// pending. A frame taken after a non-looping sound has ended, or at a buffer start with no
// frames left, gives no result. tlast marks the last frame of a buffer or the end of the
// sound; tuser is the channel-enabled flag.
`timescale 1ns / 1ps
module stereo_voice_mixer_ramped_pan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [svm_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [svm_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,  // left_in, right_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [55:0]                         m_axis_tdata,  // left_out, right_out, next_position
  output logic                                m_axis_tlast,  // buffer_last
  output logic                                m_axis_tuser   // channel_enabled
);
  import svm_pkg::*;

  state_e state_q, state_d;

  logic [PositionBits-1:0] len_q;
  logic                    loop_q;
  logic [VolBits-1:0]      tvol_q;
  logic signed [PanBits-1:0] tpan_q;
  logic [DivDenBits-1:0]   bfr_q;

  logic [PositionBits-1:0] pos_q;
  logic [BufferBits-1:0]   fib_q;
  logic [DivDenBits-1:0]   n_q;
  logic [VolBits-1:0]      sv_q;
  logic signed [PanBits-1:0] sp_q;
  logic                    en_q;

  logic signed [SampleBits-1:0] xl_q, xr_q, lo_q, ro_q;
  logic [VolBits-1:0]      vol_q, gl_q, gr_q;
  logic signed [PanBits-1:0] pan_q;

  logic                    ov_q;
  logic [55:0]             od_q;
  logic                    ol_q, ou_q;

  div_req_t                 div_req;
  logic                     div_done;
  logic [DivNumBits-1:0]    div_quo;
  logic signed [MulABits-1:0] mul_a;
  logic signed [MulBBits-1:0] mul_b;
  logic signed [MulPBits-1:0] mul_p;

  logic                    in_acc;
  logic [VolBits-1:0]      vt;
  logic                    v_up, p_up;
  logic [VolBits-1:0]      v_mag, p_mag;
  logic [VolBits-1:0]      q17;
  logic [DivDenBits-1:0]   bf_sat, bf;
  logic [PositionBits-1:0] left_cnt;
  logic [PanBits-1:0]      u;
  logic [VolBits-1:0]      cu;
  logic [TableBits:0]      cidx;
  logic [VolBits-1:0]      g_sin, g_cos;
  logic signed [MulPBits-1:0] rsum;
  logic signed [MulPBits-32:0] rsh;
  logic signed [SampleBits-1:0] rsat;
  logic [PositionBits:0]   pos_inc;
  logic                    wrap, snd_end, last;
  logic [PositionBits-1:0] pos_new;
  logic [BufferBits:0]     fib_inc;
  logic                    out_load;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_DONE) && (!ov_q || m_axis_tready);

  assign vt    = (tvol_q > UNITY_VOLUME) ? UNITY_VOLUME : tvol_q;
  assign v_up  = vt >= sv_q;
  assign v_mag = v_up ? (vt - sv_q) : (sv_q - vt);
  assign p_up  = tpan_q >= sp_q;
  assign p_mag = p_up ? VolBits'(17'(signed'(tpan_q)) - 17'(signed'(sp_q)))
                      : VolBits'(17'(signed'(sp_q)) - 17'(signed'(tpan_q)));
  assign q17   = div_quo[VolBits-1:0];

  always_comb begin
    bf_sat = bfr_q;
    if (bfr_q == '0) begin
      bf_sat = DivDenBits'(1);
    end else if (bfr_q > DivDenBits'(1 << BufferBits)) begin
      bf_sat = DivDenBits'(1 << BufferBits);
    end
    left_cnt = (pos_q < len_q) ? (len_q - pos_q) : '0;
    bf = bf_sat;
    if (!loop_q && (left_cnt < PositionBits'(bf_sat))) begin
      bf = left_cnt[DivDenBits-1:0];
    end
  end

  assign u     = {~pan_q[PanBits-1], pan_q[PanBits-2:0]};
  assign cu    = UNITY_VOLUME - VolBits'(u);
  assign cidx  = cu[VolBits-1:VolBits-1-TableBits];
  assign g_sin = VolBits'(GAIN_TAB[u[PanBits-1:PanBits-TableBits]]);
  assign g_cos = cidx[TableBits] ? UNITY_GAIN : VolBits'(GAIN_TAB[cidx[TableBits-1:0]]);

  assign rsum = mul_p + MulPBits'(64'd1 << 30);
  assign rsh  = rsum[MulPBits-1:31];
  always_comb begin
    if (rsh > (MulPBits-31)'(32767)) begin
      rsat = 16'sh7fff;
    end else if (rsh < -(MulPBits-31)'(32768)) begin
      rsat = 16'sh8000;
    end else begin
      rsat = rsh[SampleBits-1:0];
    end
  end

  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign wrap    = pos_inc >= {1'b0, len_q};
  assign snd_end = wrap && !loop_q;
  assign pos_new = (wrap && loop_q) ? '0 : pos_inc[PositionBits-1:0];
  assign fib_inc = {1'b0, fib_q} + 1'b1;
  assign last    = snd_end || (fib_inc >= n_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && en_q) begin
          state_d = (fib_q == '0) ? ST_START : ST_VMUL;
        end
      end
      ST_START: state_d = (bf == '0) ? ST_IDLE : ST_VMUL;
      ST_VMUL:  state_d = ST_VDIV;
      ST_VDIV:  state_d = ST_VWAIT;
      ST_VWAIT: if (div_done) state_d = ST_PMUL;
      ST_PMUL:  state_d = ST_PDIV;
      ST_PDIV:  state_d = ST_PWAIT;
      ST_PWAIT: if (div_done) state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_LMUL1;
      ST_LMUL1: state_d = ST_LMUL2;
      ST_LMUL2: state_d = ST_RMUL1;
      ST_RMUL1: state_d = ST_RMUL2;
      ST_RMUL2: state_d = ST_RRND;
      ST_RRND:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = mul_p[DivNumBits-1:0];
    div_req.divisor  = n_q;
    s_axis_tready    = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_VMUL: begin
        mul_a = MulABits'(v_mag);
        mul_b = MulBBits'(fib_q);
      end
      ST_PMUL: begin
        mul_a = MulABits'(p_mag);
        mul_b = MulBBits'(fib_q);
      end
      ST_VDIV, ST_PDIV: div_req.start = 1'b1;
      ST_LMUL1: begin
        mul_a = MulABits'(xl_q);
        mul_b = MulBBits'(gl_q);
      end
      ST_LMUL2, ST_RMUL2: begin
        mul_a = mul_p[MulABits-1:0];
        mul_b = MulBBits'(vol_q);
      end
      ST_RMUL1: begin
        mul_a = MulABits'(xr_q);
        mul_b = MulBBits'(gr_q);
      end
      default: ;
    endcase
  end

  svm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  svm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= PositionBits'(1);
      loop_q  <= 1'b0;
      tvol_q  <= '0;
      tpan_q  <= '0;
      bfr_q   <= DivDenBits'(1024);
      pos_q   <= '0;
      fib_q   <= '0;
      n_q     <= '0;
      sv_q    <= '0;
      sp_q    <= '0;
      en_q    <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SOUND_LENGTH:  len_q  <= cfg_data_i[PositionBits-1:0];
          CFG_LOOP_ENABLE:   loop_q <= cfg_data_i[0];
          CFG_TARGET_VOLUME: tvol_q <= cfg_data_i[VolBits-1:0];
          CFG_TARGET_PAN:    tpan_q <= cfg_data_i[PanBits-1:0];
          CFG_BUFFER_FRAMES: bfr_q  <= cfg_data_i[DivDenBits-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_START) begin
        if (bf == '0) begin
          sv_q <= vt;
          sp_q <= tpan_q;
          en_q <= loop_q || (pos_q < len_q);
        end else begin
          n_q <= bf;
        end
      end
      if (out_load) begin
        pos_q <= pos_new;
        if (last) begin
          fib_q <= '0;
          sv_q  <= vt;
          sp_q  <= tpan_q;
          en_q  <= loop_q || (pos_new < len_q);
        end else begin
          fib_q <= fib_inc[BufferBits-1:0];
        end
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xl_q <= s_axis_tdata[15:0];
      xr_q <= s_axis_tdata[31:16];
    end
    if (state_q == ST_VWAIT && div_done) begin
      vol_q <= v_up ? (sv_q + q17) : (sv_q - q17);
    end
    if (state_q == ST_PWAIT && div_done) begin
      pan_q <= p_up ? PanBits'(17'(signed'(sp_q)) + q17)
                    : PanBits'(17'(signed'(sp_q)) - q17);
    end
    if (state_q == ST_GAIN) begin
      gl_q <= g_cos;
      gr_q <= g_sin;
    end
    if (state_q == ST_RMUL1) begin
      lo_q <= rsat;
    end
    if (state_q == ST_RRND) begin
      ro_q <= rsat;
    end
    if (out_load) begin
      od_q <= {pos_new, ro_q, lo_q};
      ol_q <= last;
      ou_q <= last ? (loop_q || (pos_new < len_q)) : en_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = ou_q;

endmodule

/* rtl/core/svm_checker.sv */
// port-level checks for the stereo voice mixer, bound to the top level
`timescale 1ns / 1ps
module svm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  a_no_valid_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_disable_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("channel disabled on a frame that is not last");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transaction changed");

  a_disabled_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tuser) |=> !m_axis_tvalid)
    else $error("result after channel disabled");

endmodule

bind stereo_voice_mixer_ramped_pan svm_checker u_svm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
